// ===== hw/rtl/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;
   localparam int NUM_UNITS_DEF = 128;
   localparam int LEN_W = 8;
   localparam int TAG_W = LEN_W + 1;
   localparam int POS_W = LEN_W + 1;
   localparam int DIV_W = 32;
   localparam int UNIT_W = 16;
   localparam int ADDR_W = 32;
   localparam int REQ_W = 24;
   localparam logic [UNIT_W-1:0] UNIT_BYTES_RST = 16'd200;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_BAD_ADDR  = 2'd2
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_UNIT_BYTES = 1'b0,
      CSR_POOL_BASE  = 1'b1
   } csr_type;
endpackage
`default_nettype wire

// ===== hw/rtl/first_fit_unit_allocator.sv =====
// First-fit unit allocator. Pulse start with busy low to issue an allocate or
// a free. One result comes back on rsp_valid for a single cycle and cannot be
// stalled, so the receiver must take it then. After an item is accepted, busy
// stays high for the following phases:
//    - bit-serial division (byte count by unit size, or address offset by
//      unit size);
//    - a setup step;
//    - a read and a check for each run visited in the first-fit walk through
//      the tag memory (one read and one write port), plus a final read step
//      when an allocate runs off the end of the pool;
//    - two tag writes (exact fit) or four tag writes (split) and then the
//      multiply for an allocate; reads of the previous and next run and up
//      to two tag writes for a free;
//    - a finishing step.
// A free whose address is misaligned or out of range ends right after the
// setup step. The result is on the ports in the first cycle that busy is
// low. No clearing pass is needed after reset. Configuration writes are
// taken at any time but must only be issued while busy is low.
`default_nettype none
module first_fit_unit_allocator #(
   parameter int NUM_UNITS = ffa_pkg::NUM_UNITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_command,
   input  wire logic [ffa_pkg::REQ_W-1:0]   req_request_bytes,
   input  wire logic [ffa_pkg::ADDR_W-1:0]  req_free_address,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [ffa_pkg::ADDR_W-1:0]       rsp_granted_address,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [31:0]                 csr_wdata
);
   localparam int IW = $clog2(NUM_UNITS);
   localparam int PW = ffa_pkg::POS_W;
   localparam int LW = ffa_pkg::LEN_W;
   localparam int TW = ffa_pkg::TAG_W;
   localparam int EW = PW + 2;
   localparam int DW = ffa_pkg::DIV_W;
   localparam int UW = ffa_pkg::UNIT_W;
   localparam int CW = $clog2(DW);
   localparam logic [PW-1:0] NP = PW'(NUM_UNITS);

   typedef enum logic [13:0] {
      S_IDLE   = 14'h0001,
      S_DIV    = 14'h0002,
      S_PREP   = 14'h0004,
      S_WRD    = 14'h0008,
      S_WCHK   = 14'h0010,
      S_PRD    = 14'h0020,
      S_PCHK   = 14'h0040,
      S_NRD    = 14'h0080,
      S_NCHK   = 14'h0100,
      S_WR0    = 14'h0200,
      S_WR1    = 14'h0400,
      S_WR2    = 14'h0800,
      S_WR3    = 14'h1000,
      S_MUL    = 14'h2000
   } state_type;

   state_type state_ff, state_in;
   logic fin_ff, fin_in;

   logic [UW-1:0] unit_ff;
   logic [ffa_pkg::ADDR_W-1:0] base_ff;
   logic [UW-1:0] ub;

   logic [TW-1:0] mem [NUM_UNITS];
   logic [NUM_UNITS-1:0] vld_ff;
   logic [TW-1:0] rd_data_ff, rd_rst_ff;
   logic rd_vld_ff;
   logic [TW-1:0] tag;
   logic [EW-1:0] rd_addr, wr_addr;
   logic wr_en;
   logic [TW-1:0] wr_tag;

   logic cmd_ff, cmd_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [UW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] pos_ff, pos_in, idx_ff, idx_in, len_ff, len_in, need_ff, need_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW:0] total_ff, total_in;
   logic big_ff, big_in;
   logic [1:0] stat_ff, stat_in;
   logic [LW+UW-1:0] prod_ff, prod_in;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [ffa_pkg::ADDR_W-1:0] rsp_addr_ff;

   logic [UW:0] trial;
   logic [UW:0] diffr;
   logic [ffa_pkg::REQ_W:0] need_full;
   logic [PW:0] pl_sum;
   logic [LW-1:0] tlen;
   logic [PW-1:0] rl;
   logic [EW-1:0] end_addr;

   assign ub = (unit_ff == '0) ? UW'(1) : unit_ff;
   assign busy = (state_ff != S_IDLE) || fin_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign tag = rd_vld_ff ? rd_data_ff : rd_rst_ff;
   assign tlen = tag[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= ffa_pkg::UNIT_BYTES_RST;
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (ffa_pkg::csr_type'(csr_index))
            ffa_pkg::CSR_UNIT_BYTES: unit_ff <= csr_wdata[UW-1:0];
            ffa_pkg::CSR_POOL_BASE:  base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tag memory; entries never written read as the reset layout
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[IW-1:0]] <= wr_tag;
      rd_data_ff <= mem[rd_addr[IW-1:0]];
      rd_rst_ff <= (rd_addr == '0 || rd_addr == EW'(NUM_UNITS - 1)) ?
                   {1'b0, NP[LW-1:0]} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr[IW-1:0]] <= 1'b1;
         rd_vld_ff <= vld_ff[rd_addr[IW-1:0]];
      end
   end

   always_comb begin
      state_in = state_ff;
      fin_in = 1'b0;
      cmd_in = cmd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      need_in = need_ff;
      start_in = start_ff;
      total_in = total_ff;
      big_in = big_ff;
      stat_in = stat_ff;
      prod_in = prod_ff;
      rd_addr = EW'(pos_ff);
      wr_en = 1'b0;
      wr_addr = EW'(pos_ff);
      wr_tag = '0;
      trial = {rem_ff, quo_ff[DW-1]};
      diffr = trial - {1'b0, ub};
      need_full = '0;
      pl_sum = '0;
      rl = '0;
      end_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               cmd_in = req_command;
               quo_in = (req_command == ffa_pkg::CMD_FREE) ?
                        req_free_address - base_ff : DW'(req_request_bytes);
               rem_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring-division bit per cycle
            if (!diffr[UW]) begin
               rem_in = diffr[UW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = trial[UW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) state_in = S_PREP;
         end
         S_PREP: begin
            pos_in = '0;
            if (cmd_ff == ffa_pkg::CMD_ALLOC) begin
               need_full = quo_ff[ffa_pkg::REQ_W:0] +
                           (ffa_pkg::REQ_W+1)'(rem_ff != '0);
               if (need_full == '0) need_full = (ffa_pkg::REQ_W+1)'(1);
               big_in = (need_full[ffa_pkg::REQ_W:LW] != '0);
               need_in = PW'(need_full[LW-1:0]);
               state_in = S_WRD;
            end else if (rem_ff != '0 || quo_ff >= DW'(NUM_UNITS)) begin
               stat_in = ffa_pkg::ST_BAD_ADDR;
               fin_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = quo_ff[PW-1:0];
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            rd_addr = EW'(pos_ff);
            if (pos_ff >= NP) begin
               stat_in = (cmd_ff == ffa_pkg::CMD_FREE) ?
                         ffa_pkg::ST_BAD_ADDR : ffa_pkg::ST_NO_SPACE;
               fin_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            pl_sum = {1'b0, pos_ff} + (PW+1)'(tlen);
            rl = (tlen == '0 || pl_sum > (PW+1)'(NP)) ? '0 : PW'(tlen);
            state_in = S_WRD;
            pos_in = pl_sum[PW-1:0];
            if (cmd_ff == ffa_pkg::CMD_ALLOC) begin
               if (rl == '0) begin
                  stat_in = ffa_pkg::ST_NO_SPACE;
                  fin_in = 1'b1;
                  state_in = S_IDLE;
               end else if (!tag[LW] && !big_ff && rl >= need_ff) begin
                  pos_in = pos_ff;
                  len_in = rl;
                  state_in = S_WR0;
               end
            end else begin
               if (rl == '0 || pos_ff > idx_ff ||
                   (pos_ff == idx_ff && !tag[LW])) begin
                  stat_in = ffa_pkg::ST_BAD_ADDR;
                  fin_in = 1'b1;
                  state_in = S_IDLE;
               end else if (pos_ff == idx_ff) begin
                  len_in = rl;
                  start_in = idx_ff;
                  total_in = {1'b0, rl};
                  state_in = S_PRD;
               end
            end
         end
         S_PRD: begin
            rd_addr = EW'(idx_ff - PW'(1));
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (idx_ff != '0 && !tag[LW] && tlen != '0 && PW'(tlen) <= idx_ff) begin
               start_in = idx_ff - PW'(tlen);
               total_in = total_ff + (PW+1)'(tlen);
            end
            state_in = S_NRD;
         end
         S_NRD: begin
            rd_addr = EW'(idx_ff) + EW'(len_ff);
            state_in = S_NCHK;
         end
         S_NCHK: begin
            pl_sum = {1'b0, idx_ff} + {1'b0, len_ff};
            if (pl_sum < (PW+1)'(NP) && !tag[LW] && tlen != '0 &&
                pl_sum + (PW+1)'(tlen) <= (PW+1)'(NP))
               total_in = total_ff + (PW+1)'(tlen);
            state_in = S_WR0;
         end
         S_WR0: begin
            wr_en = 1'b1;
            if (cmd_ff == ffa_pkg::CMD_ALLOC) begin
               wr_addr = EW'(pos_ff);
               wr_tag = {1'b1, need_ff[LW-1:0]};
            end else begin
               wr_addr = EW'(start_ff);
               wr_tag = {1'b0, total_ff[LW-1:0]};
            end
            state_in = S_WR1;
         end
         S_WR1: begin
            if (cmd_ff == ffa_pkg::CMD_ALLOC) begin
               wr_en = 1'b1;
               wr_addr = EW'(pos_ff) + EW'(need_ff) - EW'(1);
               wr_tag = {1'b1, need_ff[LW-1:0]};
               state_in = (len_ff > need_ff) ? S_WR2 : S_MUL;
            end else begin
               end_addr = EW'(start_ff) + EW'(total_ff) - EW'(1);
               wr_addr = end_addr;
               wr_tag = {1'b0, total_ff[LW-1:0]};
               wr_en = (end_addr < EW'(NUM_UNITS));
               stat_in = ffa_pkg::ST_OK;
               fin_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WR2: begin
            wr_en = 1'b1;
            wr_addr = EW'(pos_ff) + EW'(need_ff);
            wr_tag = {1'b0, LW'(len_ff - need_ff)};
            state_in = S_WR3;
         end
         S_WR3: begin
            wr_en = 1'b1;
            wr_addr = EW'(pos_ff) + EW'(len_ff) - EW'(1);
            wr_tag = {1'b0, LW'(len_ff - need_ff)};
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = (LW+UW)'(pos_ff[LW-1:0]) * (LW+UW)'(ub);
            stat_in = ffa_pkg::ST_OK;
            fin_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         rsp_valid_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
      need_ff <= need_in;
      start_ff <= start_in;
      total_ff <= total_in;
      big_ff <= big_in;
      stat_ff <= stat_in;
      prod_ff <= prod_in;
      if (fin_ff) begin
         rsp_status_ff <= stat_ff;
         rsp_addr_ff <= (cmd_ff == ffa_pkg::CMD_ALLOC && stat_ff == ffa_pkg::ST_OK) ?
                        base_ff + ffa_pkg::ADDR_W'(prod_ff) : '0;
      end
   end

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(fin_ff)) else $error("result without finish");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item accepted but not busy");
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffa_pkg::ST_OK) |-> rsp_granted_address == '0)
      else $error("failed item reports an address");
   a_fin_pulse: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> !fin_ff) else $error("finish held two cycles");
endmodule
`default_nettype wire
